FILE: hdl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg - shared types and constants of the text console character writer
//
// Character codes, the reset value of a screen cell, and the command and
// status groups exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Character codes with special meaning on a put
   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_SPACE     = 8'd32;

   // Cell contents after reset: blank, grey on black
   localparam logic [15:0] CELL_RESET = 16'h0720;

   // Reset value of the attribute register
   localparam logic [7:0] ATTR_RESET = 8'h07;

   // Controller to datapath
   typedef struct packed {
      logic capture;      // latch the incoming request beat
      logic exec;         // apply the latched request (cursor, cell write/read)
      logic clear_step;   // write one cell of the post-reset clearing pass
      logic scroll_step;  // blank one cell of the recycled row
      logic load_out;     // load the response register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scroll;       // latched put runs past the last row
      logic clear_last;   // clearing pass is at the last cell
      logic scroll_last;  // row blanking is at the last column
   } sts_type;

endpackage

FILE: hdl/text_console_char_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_top - text-mode console character writer
//
// Request channel (req_): a put beat (mode 0) writes one byte at the cursor,
// with newline and backspace handled as control codes; a read beat (mode 1)
// fetches one screen cell by linear index. Every request gives exactly one
// response beat (rsp_) with the cursor after the request, the cell read
// (zero on a put) and a scroll flag. csr_wr_en/csr_wr_data set the
// attribute byte used for written and blanked cells.
// Sequencing: a taken request is executed, then its response is loaded;
// a new request is taken in the same cycle the response is loaded, and
// not before. A put that scrolls also blanks the recycled row of the store,
// one cell at a time, before its response is loaded; the store is a ring of
// rows addressed through a top-row base, so no rows are copied.
// Reset: the cursor goes home, the attribute goes to 0x07 and the store is
// cleared to 0x0720 one cell a cycle, with req_stall high throughout.
// A stalled response is held in the output register; one more request is
// taken and worked while it waits, then req_stall stays high.
// ----------------------------------------------------------------------------
module text_console_char_writer_top #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [10:0] rsp_cursor_position,
   output logic [4:0]  rsp_cursor_row,
   output logic [6:0]  rsp_cursor_column,
   output logic [15:0] rsp_cell_data,
   output logic        rsp_did_scroll,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   tcw_pkg::cmd_type cmd;
   tcw_pkg::sts_type sts;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcw_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_mode            (req_mode),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .cmd                 (cmd),
      .sts                 (sts),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_column   (rsp_cursor_column),
      .rsp_cell_data       (rsp_cell_data),
      .rsp_did_scroll      (rsp_did_scroll)
   );

   // Response register is only overwritten when it is free
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || !rsp_stall))
      else $error("response overwritten while stalled");

   // A taken request is executed in the next cycle
   a_capture_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.exec)
      else $error("taken request not executed");

   // No request taken at the start of the clearing pass
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("request taken during clearing pass");

endmodule

FILE: hdl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram - generic simple dual-port RAM
//
// One write port and one read port, registered read data that holds until
// the next read.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage array, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl - sequencing controller of the text console character writer
//
// Runs the clearing pass after reset, steps each request through execute,
// optional row blanking on a scroll, and the response register handoff.
// ----------------------------------------------------------------------------
module tcw_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  tcw_pkg::sts_type sts,
   output tcw_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_SCROLL = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       accept;

   // Response register can take a new beat
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_DONE) && out_free));
   assign accept    = req_valid && !req_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.capture = accept;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.scroll ? ST_SCROLL : ST_DONE;
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (sts.scroll_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = accept ? ST_EXEC : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid flag
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/tcw_dp.sv
// ----------------------------------------------------------------------------
// tcw_dp - datapath of the text console character writer
//
// Request latch, cursor and attribute registers, ring-buffer screen store
// with a top-row base pointer, sweep counter and response register.
// ----------------------------------------------------------------------------
module tcw_dp #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_mode,
   input  logic [7:0]       req_char_code,
   input  logic [10:0]      req_cell_index,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   input  tcw_pkg::cmd_type  cmd,
   output tcw_pkg::sts_type  sts,
   output logic [10:0]      rsp_cursor_position,
   output logic [4:0]       rsp_cursor_row,
   output logic [6:0]       rsp_cursor_column,
   output logic [15:0]      rsp_cell_data,
   output logic             rsp_did_scroll
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int AW  = $clog2(CELL_COUNT);
   localparam int AW1 = AW + 1;
   localparam int CW  = $clog2(COLUMNS);
   localparam int RW  = $clog2(ROWS);
   localparam logic [AW:0]   CELLS_W    = AW1'(CELL_COUNT);
   localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);
   localparam logic [AW-1:0] ONE_A      = AW'(1);
   localparam logic [AW-1:0] CLEAR_LAST = AW'(CELL_COUNT - 1);
   localparam logic [AW-1:0] COL_LAST_A = AW'(COLUMNS - 1);
   localparam logic [CW-1:0] COL_LAST   = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);

   // Request latch
   logic          mode_ff;
   logic [7:0]    char_ff;
   logic [10:0]   cidx_ff;

   // Cursor, attribute, store base and sweep counter
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] base_ff, base_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [7:0]    attr_ff;
   logic          scroll_ff, scroll_in;

   // Response register
   logic [10:0]   opos_ff;
   logic [4:0]    orow_ff;
   logic [6:0]    ocol_ff;
   logic [15:0]   odata_ff;
   logic          oscr_ff;

   // Decode and address path
   logic          is_nl, is_bs, is_chr;
   logic          last_col, last_row;
   logic          in_range;
   logic          pos_zero;
   logic [AW-1:0] log_addr;
   logic [AW:0]   sum;
   logic [AW-1:0] phys_addr;
   logic [AW:0]   base_next;

   // RAM ports
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [15:0]   ram_wdata;
   logic          ram_re;
   logic [15:0]   ram_rdata;

   assign is_nl    = !mode_ff && (char_ff == tcw_pkg::CH_NEWLINE);
   assign is_bs    = !mode_ff && (char_ff == tcw_pkg::CH_BACKSPACE);
   assign is_chr   = !mode_ff && !is_nl && !is_bs;
   assign last_col = (col_ff == COL_LAST);
   assign last_row = (row_ff == ROW_LAST);
   assign in_range = (32'(cidx_ff) < 32'(CELL_COUNT));
   assign pos_zero = (pos_ff == '0);

   // Logical cell address, then rotate by the top-row base
   always_comb begin
      if (mode_ff) begin
         log_addr = AW'(cidx_ff);
      end else if (is_bs) begin
         log_addr = pos_ff - ONE_A;
      end else begin
         log_addr = pos_ff;
      end
      sum = {1'b0, log_addr} + {1'b0, base_ff};
      if (sum >= CELLS_W) begin
         phys_addr = AW'(sum - CELLS_W);
      end else begin
         phys_addr = sum[AW-1:0];
      end
   end

   // Status to the controller
   assign sts.scroll      = !mode_ff && last_row && (is_nl || (is_chr && last_col));
   assign sts.clear_last  = (cnt_ff == CLEAR_LAST);
   assign sts.scroll_last = (cnt_ff == COL_LAST_A);

   // Cursor update on a put
   always_comb begin
      row_in    = row_ff;
      col_in    = col_ff;
      pos_in    = pos_ff;
      scroll_in = scroll_ff;
      if (cmd.exec) begin
         scroll_in = sts.scroll;
         if (is_nl) begin
            col_in = '0;
            if (last_row) begin
               pos_in = pos_ff - AW'(col_ff);
            end else begin
               row_in = row_ff + 1'b1;
               pos_in = pos_ff - AW'(col_ff) + COLS_A;
            end
         end else if (is_bs) begin
            if (!pos_zero) begin
               pos_in = pos_ff - ONE_A;
               if (col_ff != '0) begin
                  col_in = col_ff - 1'b1;
               end else begin
                  row_in = row_ff - 1'b1;
                  col_in = COL_LAST;
               end
            end
         end else if (is_chr) begin
            if (last_col) begin
               col_in = '0;
               if (last_row) begin
                  pos_in = pos_ff + ONE_A - COLS_A;
               end else begin
                  row_in = row_ff + 1'b1;
                  pos_in = pos_ff + ONE_A;
               end
            end else begin
               col_in = col_ff + 1'b1;
               pos_in = pos_ff + ONE_A;
            end
         end
      end
   end

   // Sweep counter and store base
   assign base_next = {1'b0, base_ff} + {1'b0, COLS_A};

   always_comb begin
      cnt_in  = cnt_ff;
      base_in = base_ff;
      if (cmd.exec) begin
         cnt_in = '0;
      end else if (cmd.clear_step || cmd.scroll_step) begin
         cnt_in = cnt_ff + ONE_A;
      end
      if (cmd.scroll_step && sts.scroll_last) begin
         base_in = (base_next == CELLS_W) ? '0 : base_next[AW-1:0];
      end
   end

   // Store write and read selection
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = phys_addr;
      ram_wdata = {attr_ff, tcw_pkg::CH_SPACE};
      ram_re    = 1'b0;
      if (cmd.clear_step) begin
         ram_we    = 1'b1;
         ram_waddr = cnt_ff;
         ram_wdata = tcw_pkg::CELL_RESET;
      end else if (cmd.scroll_step) begin
         ram_we    = 1'b1;
         ram_waddr = base_ff + cnt_ff;
      end else if (cmd.exec) begin
         ram_we = is_chr || (is_bs && !pos_zero);
         ram_re = mode_ff && in_range;
         if (is_chr) begin
            ram_wdata = {attr_ff, char_ff};
         end
      end
   end

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (phys_addr),
      .rd_data (ram_rdata)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= '0;
         col_ff    <= '0;
         pos_ff    <= '0;
         base_ff   <= '0;
         cnt_ff    <= '0;
         scroll_ff <= 1'b0;
         attr_ff   <= tcw_pkg::ATTR_RESET;
      end else begin
         row_ff    <= row_in;
         col_ff    <= col_in;
         pos_ff    <= pos_in;
         base_ff   <= base_in;
         cnt_ff    <= cnt_in;
         scroll_ff <= scroll_in;
         if (csr_wr_en) begin
            attr_ff <= csr_wr_data;
         end
      end
   end

   // Request latch and response register, payload only
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         char_ff <= req_char_code;
         cidx_ff <= req_cell_index;
      end
      if (cmd.load_out) begin
         opos_ff  <= 11'(pos_ff);
         orow_ff  <= 5'(row_ff);
         ocol_ff  <= 7'(col_ff);
         odata_ff <= (mode_ff && in_range) ? ram_rdata : 16'd0;
         oscr_ff  <= scroll_ff;
      end
   end

   assign rsp_cursor_position = opos_ff;
   assign rsp_cursor_row      = orow_ff;
   assign rsp_cursor_column   = ocol_ff;
   assign rsp_cell_data       = odata_ff;
   assign rsp_did_scroll      = oscr_ff;

endmodule

FILE: tb/sv/text_console_char_writer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_char_writer_top_tb - self-checking bench for the console writer
//
// Queued put and read beats are driven into the block with random gaps on both
// channels. Each accepted beat runs through a behavioral copy of the screen
// store and cursor, and the predicted cursor report is compared with the next
// response beat. The attribute byte is changed between phases while idle.
// ----------------------------------------------------------------------------
module text_console_char_writer_top_tb;

   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int CELLS       = ROWS * COLUMNS;
   localparam int CYCLE_LIMIT = 800000;
   localparam int LONG_HOLD   = 400;

   localparam logic MODE_PUT  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } console_req_type;

   typedef struct packed {
      logic [10:0] cursor_position;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_column;
      logic [15:0] cell_data;
      logic        did_scroll;
   } cursor_report_type;

   // DUT connections
   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic        req_mode       = 1'b0;
   logic [7:0]  req_char_code  = 8'd0;
   logic [10:0] req_cell_index = 11'd0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [10:0] rsp_cursor_position;
   logic [4:0]  rsp_cursor_row;
   logic [6:0]  rsp_cursor_column;
   logic [15:0] rsp_cell_data;
   logic        rsp_did_scroll;
   logic        csr_wr_en      = 1'b0;
   logic [7:0]  csr_wr_data    = 8'd0;

   // Bench state
   console_req_type   pending_req[$];
   cursor_report_type expected_reports[$];
   int                mismatch_count = 0;
   int                cycle_count    = 0;
   int                send_gap       = 0;
   logic              req_took       = 1'b0;
   logic              no_idle        = 1'b0;
   int                hold_trigger   = 0;
   int                hold_seen      = 0;
   int                hold_left      = 0;
   int                stall_left     = 0;

   // Shadow of the screen store, cursor and attribute
   logic [15:0]    screen_model [0:CELLS-1];
   int unsigned    row_now;
   int unsigned    col_now;
   logic [7:0]     attr_model;

   text_console_char_writer_top #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_char_code      (req_char_code),
      .req_cell_index     (req_cell_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_cursor_position(rsp_cursor_position),
      .rsp_cursor_row     (rsp_cursor_row),
      .rsp_cursor_column  (rsp_cursor_column),
      .rsp_cell_data      (rsp_cell_data),
      .rsp_did_scroll     (rsp_did_scroll),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Move the cursor down a row; scroll the shadow store past the bottom
   function automatic logic advance_row();
      row_now++;
      if (row_now >= ROWS) begin
         for (int i = 0; i + COLUMNS < CELLS; i++)
            screen_model[i] = screen_model[i + COLUMNS];
         for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen_model[i] = {attr_model, tcw_pkg::CH_SPACE};
         row_now = ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Apply one accepted beat to the shadow state and give the cursor report
   function automatic cursor_report_type console_apply(console_req_type beat);
      cursor_report_type rep;
      logic [15:0]       data;
      logic              scrolled;
      data     = 16'd0;
      scrolled = 1'b0;
      if (beat.mode == MODE_READ) begin
         if (beat.cell_index < CELLS)
            data = screen_model[beat.cell_index];
      end else if (beat.char_code == tcw_pkg::CH_NEWLINE) begin
         col_now  = 0;
         scrolled = advance_row();
      end else if (beat.char_code == tcw_pkg::CH_BACKSPACE) begin
         if (col_now > 0) begin
            col_now--;
            screen_model[row_now * COLUMNS + col_now] = {attr_model, tcw_pkg::CH_SPACE};
         end else if (row_now > 0) begin
            row_now--;
            col_now = COLUMNS - 1;
            screen_model[row_now * COLUMNS + col_now] = {attr_model, tcw_pkg::CH_SPACE};
         end
      end else begin
         screen_model[row_now * COLUMNS + col_now] = {attr_model, beat.char_code};
         col_now++;
         if (col_now >= COLUMNS) begin
            col_now  = 0;
            scrolled = advance_row();
         end
      end
      rep.cursor_position = 11'(row_now * COLUMNS + col_now);
      rep.cursor_row      = 5'(row_now);
      rep.cursor_column   = 7'(col_now);
      rep.cell_data       = data;
      rep.did_scroll      = scrolled;
      return rep;
   endfunction

   // Idle length: mostly short, now and then long
   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 92)
         return $urandom_range(4, 12);
      return $urandom_range(25, 70);
   endfunction

   task automatic queue_beat(logic mode, logic [7:0] ch, logic [10:0] idx);
      console_req_type beat;
      beat.mode       = mode;
      beat.char_code  = ch;
      beat.cell_index = idx;
      pending_req.push_back(beat);
   endtask

   // Random text: runs of bytes, line breaks, erases and cell reads
   task automatic queue_random_text(int count);
      int          left;
      int          r;
      int          run;
      logic [10:0] idx;
      left = count;
      while (left > 0) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            queue_beat(MODE_PUT, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)));
            left--;
         end else if (r < 67) begin
            queue_beat(MODE_PUT, tcw_pkg::CH_NEWLINE, 11'($urandom_range(0, 2047)));
            left--;
         end else if (r < 77) begin
            queue_beat(MODE_PUT, tcw_pkg::CH_BACKSPACE, 11'($urandom_range(0, 2047)));
            left--;
         end else if (r < 80) begin
            // long line that wraps at the right edge
            run = $urandom_range(COLUMNS, COLUMNS + 5);
            while (run > 0 && left > 0) begin
               queue_beat(MODE_PUT, 8'($urandom_range(32, 126)), 11'd0);
               run--;
               left--;
            end
         end else begin
            r = $urandom_range(0, 99);
            if (r < 45)
               idx = 11'($urandom_range(0, CELLS - 1));
            else if (r < 70)
               idx = 11'($urandom_range(CELLS - COLUMNS, CELLS - 1));
            else if (r < 85)
               idx = 11'($urandom_range(0, COLUMNS - 1));
            else
               idx = 11'($urandom_range(CELLS, 2047));
            queue_beat(MODE_READ, 8'($urandom_range(0, 255)), idx);
            left--;
         end
      end
   endtask

   // Sender pause: nothing queued, nothing in flight
   task automatic wait_drained();
      while (pending_req.size() != 0 || expected_reports.size() != 0 || req_valid)
         @(negedge clock);
   endtask

   // Attribute write while idle, after a quiet stretch
   task automatic write_attribute(logic [7:0] value);
      repeat (COLUMNS + 10) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      attr_model   = value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pending_req.size() != 0) begin
            console_req_type beat;
            beat = pending_req.pop_front();
            req_valid      <= 1'b1;
            req_mode       <= beat.mode;
            req_char_code  <= beat.char_code;
            req_cell_index <= beat.cell_index;
            send_gap       <= (no_idle || $urandom_range(0, 1)) ? 0 : pick_idle();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall: random gaps plus an occasional long hold-off
   always @(negedge clock) begin
      if (hold_seen != hold_trigger) begin
         hold_seen <= hold_trigger;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
         stall_left <= pick_idle() - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Predict on each request beat, check each response beat
   always @(posedge clock) begin
      req_took <= req_valid && !req_stall && !reset;
      if (!reset && req_valid && !req_stall) begin
         console_req_type beat;
         beat.mode       = req_mode;
         beat.char_code  = req_char_code;
         beat.cell_index = req_cell_index;
         expected_reports.push_back(console_apply(beat));
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         cursor_report_type got;
         cursor_report_type want;
         got = {rsp_cursor_position, rsp_cursor_row, rsp_cursor_column,
                rsp_cell_data, rsp_did_scroll};
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected beat: pos %0d row %0d col %0d data %h scr %0d",
                     $time, got.cursor_position, got.cursor_row, got.cursor_column,
                     got.cell_data, got.did_scroll);
            mismatch_count++;
         end else begin
            want = expected_reports.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch expected pos %0d row %0d col %0d data %h scr %0d",
                        $time, want.cursor_position, want.cursor_row, want.cursor_column,
                        want.cell_data, want.did_scroll);
               $display("%0t:          actual   pos %0d row %0d col %0d data %h scr %0d",
                        $time, got.cursor_position, got.cursor_row, got.cursor_column,
                        got.cell_data, got.did_scroll);
               mismatch_count++;
            end
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Phases
   initial begin
      logic [7:0] attr_list [0:5];
      for (int i = 0; i < CELLS; i++)
         screen_model[i] = tcw_pkg::CELL_RESET;
      row_now    = 0;
      col_now    = 0;
      attr_model = tcw_pkg::ATTR_RESET;
      attr_list[0] = 8'h00;
      attr_list[1] = 8'hFF;
      attr_list[2] = 8'($urandom_range(0, 255));
      attr_list[3] = 8'h5A;
      attr_list[4] = 8'($urandom_range(0, 255));
      attr_list[5] = 8'h81;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset contents, index extremes, erase at home, byte extremes,
      // erase within a row and across a row boundary, wrap at the right edge
      queue_beat(MODE_READ, 8'h00, 11'd0);
      queue_beat(MODE_READ, 8'hFF, 11'd1999);
      queue_beat(MODE_READ, 8'h00, 11'd2000);
      queue_beat(MODE_READ, 8'h00, 11'd2047);
      queue_beat(MODE_PUT,  tcw_pkg::CH_BACKSPACE, 11'd0);
      queue_beat(MODE_PUT,  8'h00, 11'd2047);
      queue_beat(MODE_PUT,  8'hFF, 11'd0);
      queue_beat(MODE_PUT,  8'h41, 11'd0);
      queue_beat(MODE_READ, 8'h00, 11'd0);
      queue_beat(MODE_READ, 8'h00, 11'd1);
      queue_beat(MODE_READ, 8'h00, 11'd2);
      queue_beat(MODE_PUT,  tcw_pkg::CH_BACKSPACE, 11'd0);
      queue_beat(MODE_READ, 8'h00, 11'd2);
      queue_beat(MODE_PUT,  tcw_pkg::CH_NEWLINE, 11'd0);
      queue_beat(MODE_PUT,  tcw_pkg::CH_BACKSPACE, 11'd0);
      queue_beat(MODE_READ, 8'h00, 11'd79);
      queue_beat(MODE_PUT,  8'h5A, 11'd0);
      queue_beat(MODE_READ, 8'h00, 11'd79);
      queue_beat(MODE_PUT,  tcw_pkg::CH_NEWLINE, 11'd0);
      queue_beat(MODE_PUT,  8'h80, 11'd0);
      queue_beat(MODE_READ, 8'h00, 11'd160);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         write_attribute(attr_list[p]);
         no_idle = (p == 3);
         queue_random_text(55);
         // receiver holds off while the sender keeps offering beats
         if (p == 1)
            hold_trigger = hold_trigger + 1;
         wait_drained();
         queue_random_text(55);
         wait_drained();
      end
      no_idle = 1'b0;

      repeat (2 * COLUMNS) @(posedge clock);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

FILE: text_console_char_writer_top.f
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_ctrl.sv
hdl/tcw_dp.sv
hdl/text_console_char_writer_top.sv
tb/sv/text_console_char_writer_top_tb.sv
